// ===== hw/rtl/dasf_pkg.sv =====
`timescale 1ns / 1ps
package dasf_pkg;

    localparam logic [1:0] CFG_REST  = 2'd0;
    localparam logic [1:0] CFG_STIFF = 2'd1;
    localparam logic [1:0] CFG_DAMP  = 2'd2;

    localparam logic [30:0] REST_RESET  = 31'd65536;
    localparam logic [30:0] STIFF_RESET = 31'd65536;
    localparam logic [30:0] DAMP_RESET  = 31'd0;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic               applied;
        logic               sx;
        logic               sy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } ctx_t;

    typedef struct packed {
        ctx_t        ctx;
        logic [31:0] a;
        logic [31:0] b;
    } item_t;

    typedef struct packed {
        ctx_t        ctx;
        logic [31:0] a;
        logic [31:0] b;
        logic        sh;
    } geo_t;

endpackage

// ===== hw/rtl/damped_anchor_spring_force_2d_unit.sv =====
`timescale 1ns / 1ps
// Damped anchor spring force, 2D, Q(32-FRAC_BITS).FRAC_BITS.
// Input: a word is taken at a rising edge with start high and busy low;
// its fields are body_present, anchor_x/y, body_x/y and vel_x/y.
// Output: done is high for one cycle with applied, force_x and force_y;
// the receiver cannot hold it off and the block never needs it to.
// Config: cfg_we writes cfg_wdata into register cfg_idx (0 rest_length,
// 1 stiffness, 2 damping) at the clock edge; write only while idle.
// Throughput: one word per clock. busy only rises if the front register
// and the two-entry queue fill, which the non-stalling back end prevents.
// Pipeline: done follows the accepting edge through the front register,
// the queue register, the squares, the sum, a 32-stage square root (one
// root bit per stage), the length stage, FRAC_BITS + 1 divide stages for
// the unit vector, and 7 multiply and saturate stages.
// Reset: asynchronous, active low; clears all valid flags and the queue,
// and loads rest_length = 1.0, stiffness = 1.0, damping = 0 (FRAC_BITS 16).
module damped_anchor_spring_force_2d_unit
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               body_present,
    input  logic signed [31:0] anchor_x,
    input  logic signed [31:0] anchor_y,
    input  logic signed [31:0] body_x,
    input  logic signed [31:0] body_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [30:0]        cfg_wdata,
    output logic               done,
    output logic               applied,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y
);

    logic [30:0]     rest_reg, rest_next;
    logic [30:0]     stiff_reg, stiff_next;
    logic [30:0]     damp_reg, damp_next;
    logic            f_vld;
    dasf_pkg::item_t f_item;
    logic            q_ready;
    logic            q_vld;
    dasf_pkg::item_t q_item;

    always_comb
    begin
        rest_next  = rest_reg;
        stiff_next = stiff_reg;
        damp_next  = damp_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                dasf_pkg::CFG_REST:  rest_next  = cfg_wdata;
                dasf_pkg::CFG_STIFF: stiff_next = cfg_wdata;
                dasf_pkg::CFG_DAMP:  damp_next  = cfg_wdata;
                default:             rest_next  = rest_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg  <= dasf_pkg::REST_RESET;
            stiff_reg <= dasf_pkg::STIFF_RESET;
            damp_reg  <= dasf_pkg::DAMP_RESET;
        end
        else
        begin
            rest_reg  <= rest_next;
            stiff_reg <= stiff_next;
            damp_reg  <= damp_next;
        end
    end

    dasf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .body_present (body_present),
        .anchor_x     (anchor_x),
        .anchor_y     (anchor_y),
        .body_x       (body_x),
        .body_y       (body_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .q_ready      (q_ready),
        .f_vld        (f_vld),
        .f_item       (f_item)
    );

    dasf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld),
        .in_item  (f_item),
        .in_ready (q_ready),
        .out_vld  (q_vld),
        .out_item (q_item)
    );

    dasf_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (q_vld),
        .in_item     (q_item),
        .rest_length (rest_reg),
        .stiffness   (stiff_reg),
        .damping     (damp_reg),
        .out_vld     (done),
        .out_applied (applied),
        .out_fx      (force_x),
        .out_fy      (force_y)
    );

endmodule

// ===== hw/rtl/dasf_front.sv =====
`timescale 1ns / 1ps
module dasf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                body_present,
    input  logic signed [31:0]  anchor_x,
    input  logic signed [31:0]  anchor_y,
    input  logic signed [31:0]  body_x,
    input  logic signed [31:0]  body_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic                q_ready,
    output logic                f_vld,
    output dasf_pkg::item_t     f_item
);

    logic               vld_reg;
    logic               vld_next;
    dasf_pkg::item_t    item_reg;
    dasf_pkg::item_t    item_next;
    logic               accept;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;

    assign busy   = vld_reg & ~q_ready;
    assign accept = start & ~busy;
    assign f_vld  = vld_reg;
    assign f_item = item_reg;

    always_comb
    begin
        dx = {anchor_x[31], anchor_x} - {body_x[31], body_x};
        dy = {anchor_y[31], anchor_y} - {body_y[31], body_y};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        item_next = item_reg;
        if (accept)
        begin
            item_next.ctx.applied = body_present & ((dx != '0) | (dy != '0));
            item_next.ctx.sx      = dx[32];
            item_next.ctx.sy      = dy[32];
            item_next.ctx.vx      = vel_x;
            item_next.ctx.vy      = vel_y;
            item_next.a           = ax[31:0];
            item_next.b           = ay[31:0];
        end
        vld_next = accept | busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== hw/rtl/dasf_queue.sv =====
`timescale 1ns / 1ps
module dasf_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  dasf_pkg::item_t  in_item,
    output logic             in_ready,
    output logic             out_vld,
    output dasf_pkg::item_t  out_item
);

    localparam int PW = (dasf_pkg::QDEPTH > 1) ? $clog2(dasf_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(dasf_pkg::QDEPTH + 1);

    dasf_pkg::item_t mem_reg [0:dasf_pkg::QDEPTH-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            push;
    logic            pop;

    assign in_ready = cnt_reg != CW'(dasf_pkg::QDEPTH);
    assign push     = in_vld & in_ready;
    assign pop      = cnt_reg != '0;
    assign out_vld  = pop;
    assign out_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(dasf_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(dasf_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(dasf_pkg::QDEPTH))
        else $error("queue count above depth");

    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

// ===== hw/rtl/dasf_back.sv =====
`timescale 1ns / 1ps
module dasf_back
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  dasf_pkg::item_t    in_item,
    input  logic [30:0]        rest_length,
    input  logic [30:0]        stiffness,
    input  logic [30:0]        damping,
    output logic               out_vld,
    output logic               out_applied,
    output logic signed [31:0] out_fx,
    output logic signed [31:0] out_fy
);

    localparam int SQ_N = 32;
    localparam int DV_N = FRAC_BITS + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NW   = FRAC_BITS + 2;
    localparam int PXW  = 32 + NW;
    localparam int VW   = 33 + NW;
    localparam int VNW  = VW - FRAC_BITS;
    localparam int DPW  = 31 + VNW;
    localparam int PHW  = 32 + QW;
    localparam int FW   = 64 + QW;
    localparam int MGW  = FW - FRAC_BITS;
    localparam int LAT  = 2 + SQ_N + 1 + DV_N + 7;

    function automatic logic [31:0] sat32(input logic [MGW-1:0] mag, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (mag > MGW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-mag[31:0]);
        end
        else
        begin
            r = (mag > MGW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    // squares
    logic                sq_vld_reg;
    dasf_pkg::geo_t      sq_geo_reg;
    dasf_pkg::geo_t      sq_geo_next;
    logic [61:0]         sqa_reg;
    logic [61:0]         sqa_next;
    logic [61:0]         sqb_reg;
    logic [61:0]         sqb_next;
    logic [30:0]         as;
    logic [30:0]         bs;

    always_comb
    begin
        sq_geo_next.ctx = in_item.ctx;
        sq_geo_next.a   = in_item.a;
        sq_geo_next.b   = in_item.b;
        sq_geo_next.sh  = in_item.a[31] | in_item.b[31];
        as = sq_geo_next.sh ? in_item.a[31:1] : in_item.a[30:0];
        bs = sq_geo_next.sh ? in_item.b[31:1] : in_item.b[30:0];
        sqa_next = as * as;
        sqb_next = bs * bs;
    end

    // square root, one bit per stage
    logic [SQ_N:0]   rt_vld_reg;
    dasf_pkg::geo_t  rt_geo_reg  [0:SQ_N];
    logic [63:0]     rt_rad_reg  [0:SQ_N];
    logic [63:0]     rt_rad_next [0:SQ_N];
    logic [33:0]     rt_rem_reg  [0:SQ_N];
    logic [33:0]     rt_rem_next [0:SQ_N];
    logic [31:0]     rt_root_reg [0:SQ_N];
    logic [31:0]     rt_root_next[0:SQ_N];

    always_comb
    begin
        rt_rad_next[0]  = {1'b0, 63'(sqa_reg) + 63'(sqb_reg)};
        rt_rem_next[0]  = '0;
        rt_root_next[0] = '0;
    end

    genvar k;
    generate
        for (k = 0; k < SQ_N; k++)
        begin : g_sqrt
            logic [35:0] r2;
            logic [35:0] tr;
            logic        ge;
            always_comb
            begin
                r2 = {rt_rem_reg[k], rt_rad_reg[k][63:62]};
                tr = {2'b00, rt_root_reg[k], 2'b01};
                ge = r2 >= tr;
                rt_rem_next[k+1]  = ge ? 34'(r2 - tr) : r2[33:0];
                rt_root_next[k+1] = {rt_root_reg[k][30:0], ge};
                rt_rad_next[k+1]  = {rt_rad_reg[k][61:0], 2'b00};
            end
            always_ff @(posedge clk)
            begin
                rt_geo_reg[k+1]  <= rt_geo_reg[k];
                rt_rad_reg[k+1]  <= rt_rad_next[k+1];
                rt_rem_reg[k+1]  <= rt_rem_next[k+1];
                rt_root_reg[k+1] <= rt_root_next[k+1];
            end
        end
    endgenerate

    // unit vector, restoring division, one quotient bit per stage
    logic [DV_N:0]   dv_vld_reg;
    dasf_pkg::ctx_t  dv_ctx_reg  [0:DV_N];
    logic [32:0]     dv_len_reg  [0:DV_N];
    logic [33:0]     dv_rx_reg   [0:DV_N];
    logic [33:0]     dv_rx_next  [0:DV_N];
    logic [33:0]     dv_ry_reg   [0:DV_N];
    logic [33:0]     dv_ry_next  [0:DV_N];
    logic [QW-1:0]   dv_qx_reg   [0:DV_N];
    logic [QW-1:0]   dv_qx_next  [0:DV_N];
    logic [QW-1:0]   dv_qy_reg   [0:DV_N];
    logic [QW-1:0]   dv_qy_next  [0:DV_N];
    logic [32:0]     dv_len_next;

    always_comb
    begin
        dv_len_next   = rt_geo_reg[SQ_N].sh ? {rt_root_reg[SQ_N], 1'b0}
                                            : {1'b0, rt_root_reg[SQ_N]};
        dv_rx_next[0] = {2'b00, rt_geo_reg[SQ_N].a};
        dv_ry_next[0] = {2'b00, rt_geo_reg[SQ_N].b};
        dv_qx_next[0] = '0;
        dv_qy_next[0] = '0;
    end

    genvar j;
    generate
        for (j = 0; j < DV_N; j++)
        begin : g_div
            logic [33:0] sx;
            logic [33:0] sy;
            logic [33:0] dl;
            logic        gx;
            logic        gy;
            always_comb
            begin
                dl = {1'b0, dv_len_reg[j]};
                if (j == 0)
                begin
                    sx = dv_rx_reg[j];
                    sy = dv_ry_reg[j];
                end
                else
                begin
                    sx = {dv_rx_reg[j][32:0], 1'b0};
                    sy = {dv_ry_reg[j][32:0], 1'b0};
                end
                gx = sx >= dl;
                gy = sy >= dl;
                dv_rx_next[j+1] = gx ? sx - dl : sx;
                dv_ry_next[j+1] = gy ? sy - dl : sy;
                dv_qx_next[j+1] = {dv_qx_reg[j][QW-2:0], gx};
                dv_qy_next[j+1] = {dv_qy_reg[j][QW-2:0], gy};
            end
            always_ff @(posedge clk)
            begin
                dv_ctx_reg[j+1] <= dv_ctx_reg[j];
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_rx_reg[j+1]  <= dv_rx_next[j+1];
                dv_ry_reg[j+1]  <= dv_ry_next[j+1];
                dv_qx_reg[j+1]  <= dv_qx_next[j+1];
                dv_qy_reg[j+1]  <= dv_qy_next[j+1];
            end
        end
    endgenerate

    // force stages
    logic                    m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    logic                    m5_vld_reg, m6_vld_reg, m7_vld_reg;
    dasf_pkg::ctx_t          m1_ctx_reg, m2_ctx_reg, m3_ctx_reg, m4_ctx_reg;
    dasf_pkg::ctx_t          m5_ctx_reg, m6_ctx_reg;
    logic [QW-1:0]           m1_qx_reg, m2_qx_reg, m3_qx_reg, m4_qx_reg, m5_qx_reg;
    logic [QW-1:0]           m1_qy_reg, m2_qy_reg, m3_qy_reg, m4_qy_reg, m5_qy_reg;
    logic signed [NW-1:0]    nx;
    logic signed [NW-1:0]    ny;
    logic signed [PXW-1:0]   m1_px_reg, m1_px_next;
    logic signed [PXW-1:0]   m1_py_reg, m1_py_next;
    logic signed [33:0]      m1_x_reg, m1_x_next;
    logic signed [VW-1:0]    vsum;
    logic [VW-1:0]           vmag;
    logic [VNW-1:0]          m2_vn_reg, m2_vn_next;
    logic                    m2_vneg_reg, m3_vneg_reg;
    logic [33:0]             m2_xm_reg, m2_xm_next;
    logic                    m2_xneg_reg, m3_xneg_reg;
    logic [64:0]             m3_sp_reg, m3_sp_next;
    logic [DPW-1:0]          m3_dp_reg, m3_dp_next;
    logic signed [63:0]      m4_ss_reg, m4_ss_next;
    logic signed [63:0]      m4_dd_reg, m4_dd_next;
    logic signed [63:0]      tt;
    logic [63:0]             m5_mt_reg, m5_mt_next;
    logic                    m5_tneg_reg;
    logic [PHW-1:0]          m6_phx_reg, m6_phx_next, m6_plx_reg, m6_plx_next;
    logic [PHW-1:0]          m6_phy_reg, m6_phy_next, m6_ply_reg, m6_ply_next;
    logic                    m6_negx_reg, m6_negy_reg;
    logic [FW-1:0]           fullx, fully;
    logic                    m7_app_reg;
    logic [31:0]             m7_fx_reg, m7_fx_next;
    logic [31:0]             m7_fy_reg, m7_fy_next;

    always_comb
    begin
        nx = dv_ctx_reg[DV_N].sx ? -$signed({1'b0, dv_qx_reg[DV_N]})
                                 :  $signed({1'b0, dv_qx_reg[DV_N]});
        ny = dv_ctx_reg[DV_N].sy ? -$signed({1'b0, dv_qy_reg[DV_N]})
                                 :  $signed({1'b0, dv_qy_reg[DV_N]});
        m1_px_next = $signed(dv_ctx_reg[DV_N].vx) * nx;
        m1_py_next = $signed(dv_ctx_reg[DV_N].vy) * ny;
        m1_x_next  = $signed({1'b0, dv_len_reg[DV_N]}) - $signed({3'b000, rest_length});

        vsum       = VW'(m1_px_reg) + VW'(m1_py_reg);
        vmag       = vsum[VW-1] ? VW'(-vsum) : VW'(vsum);
        m2_vn_next = vmag[VW-1:FRAC_BITS];
        m2_xm_next = m1_x_reg[33] ? 34'(-m1_x_reg) : 34'(m1_x_reg);

        m3_sp_next = stiffness * m2_xm_reg;
        m3_dp_next = damping * m2_vn_reg;

        m4_ss_next = m3_xneg_reg ? -$signed(64'(m3_sp_reg[64:FRAC_BITS]))
                                 :  $signed(64'(m3_sp_reg[64:FRAC_BITS]));
        m4_dd_next = m3_vneg_reg ? -$signed(64'(m3_dp_reg[DPW-1:FRAC_BITS]))
                                 :  $signed(64'(m3_dp_reg[DPW-1:FRAC_BITS]));

        tt         = m4_ss_reg - m4_dd_reg;
        m5_mt_next = tt[63] ? 64'(-tt) : 64'(tt);

        m6_phx_next = m5_mt_reg[63:32] * m5_qx_reg;
        m6_plx_next = m5_mt_reg[31:0] * m5_qx_reg;
        m6_phy_next = m5_mt_reg[63:32] * m5_qy_reg;
        m6_ply_next = m5_mt_reg[31:0] * m5_qy_reg;

        fullx = {m6_phx_reg, 32'h0} + FW'(m6_plx_reg);
        fully = {m6_phy_reg, 32'h0} + FW'(m6_ply_reg);
        m7_fx_next = m6_ctx_reg.applied ? sat32(fullx[FW-1:FRAC_BITS], m6_negx_reg) : '0;
        m7_fy_next = m6_ctx_reg.applied ? sat32(fully[FW-1:FRAC_BITS], m6_negy_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            rt_vld_reg <= '0;
            dv_vld_reg <= '0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
            m6_vld_reg <= 1'b0;
            m7_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= in_vld;
            rt_vld_reg <= {rt_vld_reg[SQ_N-1:0], sq_vld_reg};
            dv_vld_reg <= {dv_vld_reg[DV_N-1:0], rt_vld_reg[SQ_N]};
            m1_vld_reg <= dv_vld_reg[DV_N];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
            m6_vld_reg <= m5_vld_reg;
            m7_vld_reg <= m6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_geo_reg      <= sq_geo_next;
        sqa_reg         <= sqa_next;
        sqb_reg         <= sqb_next;
        rt_geo_reg[0]   <= sq_geo_reg;
        rt_rad_reg[0]   <= rt_rad_next[0];
        rt_rem_reg[0]   <= rt_rem_next[0];
        rt_root_reg[0]  <= rt_root_next[0];
        dv_ctx_reg[0]   <= rt_geo_reg[SQ_N].ctx;
        dv_len_reg[0]   <= dv_len_next;
        dv_rx_reg[0]    <= dv_rx_next[0];
        dv_ry_reg[0]    <= dv_ry_next[0];
        dv_qx_reg[0]    <= dv_qx_next[0];
        dv_qy_reg[0]    <= dv_qy_next[0];

        m1_ctx_reg  <= dv_ctx_reg[DV_N];
        m1_qx_reg   <= dv_qx_reg[DV_N];
        m1_qy_reg   <= dv_qy_reg[DV_N];
        m1_px_reg   <= m1_px_next;
        m1_py_reg   <= m1_py_next;
        m1_x_reg    <= m1_x_next;

        m2_ctx_reg  <= m1_ctx_reg;
        m2_qx_reg   <= m1_qx_reg;
        m2_qy_reg   <= m1_qy_reg;
        m2_vn_reg   <= m2_vn_next;
        m2_vneg_reg <= vsum[VW-1];
        m2_xm_reg   <= m2_xm_next;
        m2_xneg_reg <= m1_x_reg[33];

        m3_ctx_reg  <= m2_ctx_reg;
        m3_qx_reg   <= m2_qx_reg;
        m3_qy_reg   <= m2_qy_reg;
        m3_sp_reg   <= m3_sp_next;
        m3_dp_reg   <= m3_dp_next;
        m3_xneg_reg <= m2_xneg_reg;
        m3_vneg_reg <= m2_vneg_reg;

        m4_ctx_reg  <= m3_ctx_reg;
        m4_qx_reg   <= m3_qx_reg;
        m4_qy_reg   <= m3_qy_reg;
        m4_ss_reg   <= m4_ss_next;
        m4_dd_reg   <= m4_dd_next;

        m5_ctx_reg  <= m4_ctx_reg;
        m5_qx_reg   <= m4_qx_reg;
        m5_qy_reg   <= m4_qy_reg;
        m5_mt_reg   <= m5_mt_next;
        m5_tneg_reg <= tt[63];

        m6_ctx_reg  <= m5_ctx_reg;
        m6_phx_reg  <= m6_phx_next;
        m6_plx_reg  <= m6_plx_next;
        m6_phy_reg  <= m6_phy_next;
        m6_ply_reg  <= m6_ply_next;
        m6_negx_reg <= m5_tneg_reg ^ m5_ctx_reg.sx;
        m6_negy_reg <= m5_tneg_reg ^ m5_ctx_reg.sy;

        m7_app_reg  <= m6_ctx_reg.applied;
        m7_fx_reg   <= m7_fx_next;
        m7_fy_reg   <= m7_fy_next;
    end

    assign out_vld     = m7_vld_reg;
    assign out_applied = m7_app_reg;
    assign out_fx      = m7_fx_reg;
    assign out_fy      = m7_fy_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld |-> ##LAT out_vld)
        else $error("word lost in force pipeline");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld |-> ##LAT !out_vld)
        else $error("force pipeline produced an extra word");

    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld && !out_applied) |-> (out_fx == 32'sd0 && out_fy == 32'sd0))
        else $error("force on a word with no spring");

endmodule
